// ===== rtl/pva_pkg.sv =====
`timescale 1ns / 1ps
// pva_pkg: request codes, note record, microcode word and program rom
// for the voice allocator; no dependencies
package pva_pkg;

  localparam logic [2:0] REQ_NOTE_ON  = 3'd0;
  localparam logic [2:0] REQ_NOTE_OFF = 3'd1;
  localparam logic [2:0] REQ_CHOKE    = 3'd2;
  localparam logic [2:0] REQ_ALL_OFF  = 3'd3;
  localparam logic [2:0] REQ_REPORT   = 3'd4;

  // microcode addresses
  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] UA_ON_SCAN  = 3'd0;
  localparam logic [UPC_W-1:0] UA_ON_WR    = 3'd1;
  localparam logic [UPC_W-1:0] UA_OFF_SCAN = 3'd2;
  localparam logic [UPC_W-1:0] UA_CHK_SCAN = 3'd3;
  localparam logic [UPC_W-1:0] UA_ALL_OFF  = 3'd4;
  localparam logic [UPC_W-1:0] UA_REPORT   = 3'd5;
  localparam logic [UPC_W-1:0] UA_SPARE    = 3'd6;
  localparam logic [UPC_W-1:0] UA_EMIT     = 3'd7;

  typedef struct packed {
    logic [8:0]  port;
    logic [4:0]  chan;
    logic [7:0]  key;
    logic [31:0] nid;
  } note_t;

  typedef enum logic [1:0] {
    SK_ALLOC,
    SK_RELEASE,
    SK_CHOKE
  } scan_kind_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ALLOC,
    ACT_ALL_OFF,
    ACT_REPORT
  } act_t;

  typedef struct packed {
    logic             scan;  // walk the voice table, loop here until done
    scan_kind_t       sk;
    act_t             act;
    logic             fin;   // hand the result to the output register
    logic [UPC_W-1:0] nxt;
  } uword_t;

  typedef struct packed {
    logic   run;
    logic   emit;
    uword_t w;
  } ctl_t;

  function automatic uword_t ucode_rom(logic [UPC_W-1:0] pc);
    uword_t u;
    u = '{scan: 1'b0, sk: SK_ALLOC, act: ACT_NONE, fin: 1'b0, nxt: UA_EMIT};
    unique case (pc)
      UA_ON_SCAN: begin
        u.scan = 1'b1;
        u.sk   = SK_ALLOC;
        u.nxt  = UA_ON_WR;
      end
      UA_ON_WR:    u.act = ACT_ALLOC;
      UA_OFF_SCAN: begin
        u.scan = 1'b1;
        u.sk   = SK_RELEASE;
      end
      UA_CHK_SCAN: begin
        u.scan = 1'b1;
        u.sk   = SK_CHOKE;
      end
      UA_ALL_OFF:  u.act = ACT_ALL_OFF;
      UA_REPORT:   u.act = ACT_REPORT;
      UA_SPARE:    u.fin = 1'b1;
      UA_EMIT:     u.fin = 1'b1;
      default:     u.fin = 1'b1;
    endcase
    return u;
  endfunction

  function automatic logic [UPC_W-1:0] entry_of(logic [2:0] req);
    logic [UPC_W-1:0] a;
    unique case (req)
      REQ_NOTE_ON:  a = UA_ON_SCAN;
      REQ_NOTE_OFF: a = UA_OFF_SCAN;
      REQ_CHOKE:    a = UA_CHK_SCAN;
      REQ_ALL_OFF:  a = UA_ALL_OFF;
      REQ_REPORT:   a = UA_REPORT;
      default:      a = UA_EMIT;
    endcase
    return a;
  endfunction

  // note ids decide when both are given, else each given field must agree
  function automatic logic note_match(note_t v, note_t r);
    logic m;
    if (!r.nid[31] && !v.nid[31]) begin
      m = (v.nid == r.nid);
    end else begin
      m = (r.port[8] || v.port == r.port) &&
          (r.chan[4] || v.chan == r.chan) &&
          (r.key[7]  || v.key  == r.key);
    end
    return m;
  endfunction

endpackage

// ===== rtl/polyphonic_voice_allocator_top.sv =====
`timescale 1ns / 1ps
// note_on scans the voice table, then writes the chosen voice; note_off and
// choke scan only; all_sound_off and level_report act without a scan; unknown
// requests go straight to the result; one request at a time, a new beat is
// taken the cycle after the result enters the output register
// the table walk reads one voice per cycle from the note and level rams
// reset: synchronous, clears all voices to inactive, released, level zero
module polyphonic_voice_allocator_top
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [8:0]  port_id,
  input  logic signed [4:0]  channel_num,
  input  logic signed [7:0]  key_num,
  input  logic signed [31:0] note_ident,
  input  logic [3:0]         report_voice,
  input  logic [15:0]        report_level,
  input  logic               report_idle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         voice_index,
  output logic               assigned,
  output logic               was_stolen,
  output logic [15:0]        affected_mask
);

  ctl_t        ctl;
  logic        start;
  logic        out_free;
  logic        scan_done;
  logic [3:0]  res_index;
  logic        res_assigned;
  logic        res_stolen;
  logic [15:0] res_mask;

  // input beat accepted only while the sequencer is idle
  assign in_ready = !ctl.run;
  assign start    = in_valid && in_ready;
  // output register can take a result when empty or draining this cycle
  assign out_free = !out_valid || out_ready;

  pva_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .scan_done (scan_done),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  pva_dp #(.NUM_VOICES(NUM_VOICES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .port_id      (port_id),
    .channel_num  (channel_num),
    .key_num      (key_num),
    .note_ident   (note_ident),
    .report_voice (report_voice),
    .report_level (report_level),
    .report_idle  (report_idle),
    .ctl          (ctl),
    .scan_done    (scan_done),
    .res_index    (res_index),
    .res_assigned (res_assigned),
    .res_stolen   (res_stolen),
    .res_mask     (res_mask)
  );

  // output register, parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid     <= 1'b1;
      voice_index   <= res_index;
      assigned      <= res_assigned;
      was_stolen    <= res_stolen;
      affected_mask <= res_mask;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a stolen voice only ever comes with an assignment
  a_stolen_assigned: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_stolen |-> assigned)
    else $error("stolen without assignment");

  // note_on results never carry an affected mask
  a_assign_no_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && assigned |-> affected_mask == 16'd0)
    else $error("note_on result with nonzero mask");

  // an assigned voice lies inside the table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && assigned |-> 32'(voice_index) < NUM_VOICES)
    else $error("assigned voice out of range");

  // one request at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

endmodule

// ===== rtl/pva_ram.sv =====
`timescale 1ns / 1ps
// pva_ram: generic single write port, single read port ram
// with registered read data; no dependencies
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pva_seq.sv =====
`timescale 1ns / 1ps
// pva_seq: microcode step counter, dispatch and conditional jumps
// depends on pva_pkg
module pva_seq
  import pva_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] req_type,
  input  logic       scan_done,
  input  logic       out_free,
  output ctl_t       ctl
);

  logic             busy;
  logic [UPC_W-1:0] pc;
  uword_t           w;

  assign w        = ucode_rom(pc);
  assign ctl.run  = busy;
  assign ctl.emit = busy && w.fin && out_free;
  assign ctl.w    = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= UA_EMIT;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= entry_of(req_type);
      end
    end else begin
      priority if (w.fin) begin
        if (out_free) busy <= 1'b0;
      end else if (w.scan && !scan_done) begin
        pc <= pc;
      end else begin
        pc <= w.nxt;
      end
    end
  end

endmodule

// ===== rtl/pva_dp.sv =====
`timescale 1ns / 1ps
// pva_dp: voice table datapath; active and held flags, note and level rams,
// scan pipeline and result registers; depends on pva_pkg and pva_ram
module pva_dp
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [8:0]  port_id,
  input  logic [4:0]  channel_num,
  input  logic [7:0]  key_num,
  input  logic [31:0] note_ident,
  input  logic [3:0]  report_voice,
  input  logic [15:0] report_level,
  input  logic        report_idle,
  input  ctl_t        ctl,
  output logic        scan_done,
  output logic [3:0]  res_index,
  output logic        res_assigned,
  output logic        res_stolen,
  output logic [15:0] res_mask
);

  localparam int IW = $clog2(NUM_VOICES);
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam int MW = (NUM_VOICES < 16) ? NUM_VOICES : 16;

  note_t            r_note;
  logic [3:0]       r_rv;
  logic [15:0]      r_lvl;
  logic             r_idle;

  logic [NUM_VOICES-1:0] active;
  logic [NUM_VOICES-1:0] held;
  logic [NUM_VOICES-1:0] lvl_ok;
  logic [NUM_VOICES-1:0] aff;

  logic [CW-1:0] sidx;
  logic          p_valid;
  logic [IW-1:0] p_idx;

  logic          found;
  logic [IW-1:0] free_idx;
  logic [15:0]   best_lvl;
  logic [IW-1:0] best_idx;

  logic [IW-1:0] res_idx;

  note_t         note_q;
  logic [15:0]   lvl_q;
  logic [IW-1:0] raddr;

  logic          p_active, p_held, p_match;
  logic [15:0]   p_lvl;
  logic [IW-1:0] slot;
  logic          rv_ok;
  logic [IW-1:0] rv_idx;
  logic          alloc_go, report_go;

  assign scan_done = (sidx == CW'(NUM_VOICES));
  assign raddr     = scan_done ? '0 : sidx[IW-1:0];

  assign p_active = active[p_idx];
  assign p_held   = held[p_idx];
  // never reported levels read as zero
  assign p_lvl    = lvl_ok[p_idx] ? lvl_q : 16'd0;
  assign p_match  = note_match(note_q, r_note);

  assign slot      = found ? free_idx : best_idx;
  assign rv_ok     = (32'(r_rv) < NUM_VOICES);
  assign rv_idx    = IW'(r_rv);
  assign alloc_go  = ctl.run && (ctl.w.act == ACT_ALLOC);
  assign report_go = ctl.run && (ctl.w.act == ACT_REPORT) && rv_ok;

  pva_ram #(.WIDTH($bits(note_t)), .DEPTH(NUM_VOICES)) u_note_ram (
    .clk   (clk),
    .we    (alloc_go),
    .waddr (slot),
    .wdata (r_note),
    .raddr (raddr),
    .rdata (note_q)
  );

  pva_ram #(.WIDTH(16), .DEPTH(NUM_VOICES)) u_level_ram (
    .clk   (clk),
    .we    (report_go),
    .waddr (rv_idx),
    .wdata (r_lvl),
    .raddr (raddr),
    .rdata (lvl_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      held    <= '0;
      lvl_ok  <= '0;
      sidx    <= '0;
      p_valid <= 1'b0;
    end else begin
      if (start) begin
        r_note       <= '{port: port_id, chan: channel_num, key: key_num, nid: note_ident};
        r_rv         <= report_voice;
        r_lvl        <= report_level;
        r_idle       <= report_idle;
        found        <= 1'b0;
        aff          <= '0;
        res_idx      <= '0;
        res_assigned <= 1'b0;
        res_stolen   <= 1'b0;
        sidx         <= '0;
        p_valid      <= 1'b0;
      end

      if (ctl.run && ctl.w.scan) begin
        // issue one read per cycle, process it the cycle after
        if (!scan_done) begin
          sidx    <= sidx + CW'(1);
          p_valid <= 1'b1;
          p_idx   <= sidx[IW-1:0];
        end else begin
          sidx    <= '0;
          p_valid <= 1'b0;
        end

        if (p_valid) begin
          unique case (ctl.w.sk)
            SK_ALLOC: begin
              if (!p_active && !found) begin
                found    <= 1'b1;
                free_idx <= p_idx;
              end
              if (p_idx == '0 || p_lvl < best_lvl) begin
                best_lvl <= p_lvl;
                best_idx <= p_idx;
              end
            end
            SK_RELEASE: begin
              if (p_active && p_held && p_match) begin
                held[p_idx] <= 1'b0;
                aff[p_idx]  <= 1'b1;
              end
            end
            SK_CHOKE: begin
              if (p_active && p_match) begin
                active[p_idx] <= 1'b0;
                held[p_idx]   <= 1'b0;
                aff[p_idx]    <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      if (ctl.run) begin
        unique case (ctl.w.act)
          ACT_ALLOC: begin
            active[slot] <= 1'b1;
            held[slot]   <= 1'b1;
            res_idx      <= slot;
            res_assigned <= 1'b1;
            res_stolen   <= !found;
          end
          ACT_ALL_OFF: begin
            aff    <= active;
            active <= '0;
            held   <= '0;
          end
          ACT_REPORT: begin
            if (rv_ok) begin
              lvl_ok[rv_idx] <= 1'b1;
              if (r_idle) begin
                aff[rv_idx]    <= active[rv_idx];
                active[rv_idx] <= 1'b0;
              end
            end
          end
          ACT_NONE: ;
          default: ;
        endcase
      end
    end
  end

  assign res_index = 4'(res_idx);
  assign res_mask  = 16'(aff[MW-1:0]);

endmodule

// ===== verif/polyphonic_voice_allocator_top_test.sv =====
`timescale 1ns / 1ps
// polyphonic_voice_allocator_top_test: self-checking bench for the voice allocator,
// queue-fed driver, result monitor and a voice table predictor in one module
// depends on pva_pkg and polyphonic_voice_allocator_top
module polyphonic_voice_allocator_top_test;
  import pva_pkg::*;

  localparam int NUM_VOICES        = 16;
  localparam int RANDOM_ITEMS      = 800;
  localparam int IDLE_LIMIT        = 3000;  // cycles without any beat on either side
  localparam int LONG_STALL_AT     = 300;   // results seen before the long receiver hold-off
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_AT          = 450;   // random item that waits for an empty pipe
  localparam int SETTLE_CYCLES     = 40;    // wait after the last result before the verdict
  localparam int RECENT_NOTES      = 24;
  localparam logic [2:0] REQ_FIRST_UNUSED = REQ_REPORT + 3'd1;

  // one request beat as the sender holds it
  typedef struct {
    logic [2:0]         kind;
    logic signed [8:0]  port;
    logic signed [4:0]  chan;
    logic signed [7:0]  key;
    logic signed [31:0] nid;
    logic [3:0]         rvoice;
    logic [15:0]        rlevel;
    logic               ridle;
    bit                 drain_first;  // hold back until every result is in
  } voice_req_t;

  // one result beat
  typedef struct packed {
    logic [3:0]  voice;
    logic        assigned;
    logic        stolen;
    logic [15:0] mask;
  } alloc_outcome_t;

  // clock, reset and block ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         req_type = '0;
  logic signed [8:0]  port_id = '0;
  logic signed [4:0]  channel_num = '0;
  logic signed [7:0]  key_num = '0;
  logic signed [31:0] note_ident = '0;
  logic [3:0]         report_voice = '0;
  logic [15:0]        report_level = '0;
  logic               report_idle = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         voice_index;
  logic               assigned;
  logic               was_stolen;
  logic [15:0]        affected_mask;

  always #4 clk = ~clk;

  polyphonic_voice_allocator_top #(
    .NUM_VOICES(NUM_VOICES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .port_id      (port_id),
    .channel_num  (channel_num),
    .key_num      (key_num),
    .note_ident   (note_ident),
    .report_voice (report_voice),
    .report_level (report_level),
    .report_idle  (report_idle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .voice_index  (voice_index),
    .assigned     (assigned),
    .was_stolen   (was_stolen),
    .affected_mask(affected_mask)
  );

  // ---------------------------------------------------------------------------
  // voice table predictor, updated once per accepted request beat
  // ---------------------------------------------------------------------------
  logic               tbl_active [NUM_VOICES];
  logic               tbl_held   [NUM_VOICES];
  logic signed [8:0]  tbl_port   [NUM_VOICES];
  logic signed [4:0]  tbl_chan   [NUM_VOICES];
  logic signed [7:0]  tbl_key    [NUM_VOICES];
  logic signed [31:0] tbl_nid    [NUM_VOICES];
  logic [15:0]        tbl_level  [NUM_VOICES];

  // note ids decide when both sides carry one, else every given field must agree
  function automatic logic note_hits(int v, voice_req_t r);
    if (r.nid >= 0 && tbl_nid[v] >= 0) return tbl_nid[v] == r.nid;
    return (r.port < 0 || tbl_port[v] == r.port) &&
           (r.chan < 0 || tbl_chan[v] == r.chan) &&
           (r.key  < 0 || tbl_key[v]  == r.key);
  endfunction

  function automatic alloc_outcome_t apply_to_voice_table(voice_req_t r);
    alloc_outcome_t o;
    int slot;
    o = '0;
    case (r.kind)
      REQ_NOTE_ON: begin
        // first free voice, else the quietest one with the lowest index on ties
        slot = -1;
        for (int v = 0; v < NUM_VOICES; v++)
          if (!tbl_active[v] && slot < 0) slot = v;
        if (slot < 0) begin
          slot = 0;
          for (int v = 1; v < NUM_VOICES; v++)
            if (tbl_level[v] < tbl_level[slot]) slot = v;
          o.stolen = 1'b1;
        end
        tbl_active[slot] = 1'b1;
        tbl_held[slot]   = 1'b1;
        tbl_port[slot]   = r.port;
        tbl_chan[slot]   = r.chan;
        tbl_key[slot]    = r.key;
        tbl_nid[slot]    = r.nid;
        o.voice    = 4'(slot);
        o.assigned = 1'b1;
      end
      REQ_NOTE_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (tbl_active[v] && tbl_held[v] && note_hits(v, r)) begin
            tbl_held[v] = 1'b0;
            o.mask[v]   = 1'b1;
          end
      end
      REQ_CHOKE: begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (tbl_active[v] && note_hits(v, r)) begin
            tbl_active[v] = 1'b0;
            tbl_held[v]   = 1'b0;
            o.mask[v]     = 1'b1;
          end
      end
      REQ_ALL_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          o.mask[v]     = tbl_active[v];
          tbl_active[v] = 1'b0;
          tbl_held[v]   = 1'b0;
        end
      end
      REQ_REPORT: begin
        // level is stored always; idle drops only the active flag, held stays
        tbl_level[r.rvoice] = r.rlevel;
        if (r.ridle) begin
          o.mask[r.rvoice]     = tbl_active[r.rvoice];
          tbl_active[r.rvoice] = 1'b0;
        end
      end
      default: ;  // unused request codes leave the table alone
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  voice_req_t     queued_requests[$];
  alloc_outcome_t expected_outcomes[$];
  int beats_sent   = 0;
  int results_seen = 0;
  int total_items  = 0;
  int error_count  = 0;
  bit recv_stall   = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t result %0d %s: got %0h expected %0h", $time, results_seen, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, random per-beat gap with gapless burst stretches
  // ---------------------------------------------------------------------------
  voice_req_t current_req;
  int         send_wait  = 0;
  bit         send_burst = 1'b0;

  always @(posedge clk) begin : request_driver
    logic took_beat;
    logic pipe_empty;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        tbl_active[v] = 1'b0;
        tbl_held[v]   = 1'b0;
        tbl_port[v]   = '0;
        tbl_chan[v]   = '0;
        tbl_key[v]    = '0;
        tbl_nid[v]    = -1;
        tbl_level[v]  = '0;
      end
    end else begin
      took_beat = in_valid && in_ready;
      // results_seen and beats_sent only change by nonblocking update, so this is stable
      pipe_empty = !took_beat && !in_valid && results_seen == beats_sent;
      if (took_beat) begin
        expected_outcomes.push_back(apply_to_voice_table(current_req));
        beats_sent <= beats_sent + 1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 8);
      end
      // valid holds with its payload until the beat is taken
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() > 0 &&
                     (!queued_requests[0].drain_first || pipe_empty)) begin
          current_req = queued_requests.pop_front();
          in_valid     <= 1'b1;
          req_type     <= current_req.kind;
          port_id      <= current_req.port;
          channel_num  <= current_req.chan;
          key_num      <= current_req.key;
          note_ident   <= current_req.nid;
          report_voice <= current_req.rvoice;
          report_level <= current_req.rlevel;
          report_idle  <= current_req.ridle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  int recv_wait  = 0;
  bit recv_burst = 1'b0;

  always @(posedge clk) begin : result_monitor
    alloc_outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result with nothing expected",
                          32'({voice_index, assigned, was_stolen, affected_mask}), '0);
        end else begin
          want = expected_outcomes.pop_front();
          if (voice_index !== want.voice)
            report_mismatch("voice_index", 32'(voice_index), 32'(want.voice));
          if (assigned !== want.assigned)
            report_mismatch("assigned", 32'(assigned), 32'(want.assigned));
          if (was_stolen !== want.stolen)
            report_mismatch("was_stolen", 32'(was_stolen), 32'(want.stolen));
          if (affected_mask !== want.mask)
            report_mismatch("affected_mask", 32'(affected_mask), 32'(want.mask));
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !recv_stall;
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering, fills the block
  initial begin : long_backpressure
    wait (!rst);
    while (results_seen < LONG_STALL_AT) @(posedge clk);
    recv_stall <= 1'b1;
    repeat (LONG_STALL_CYCLES) @(posedge clk);
    recv_stall <= 1'b0;
  end

  // watchdog on cycles with no beat anywhere
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("polyphonic_voice_allocator_top_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // every field random within its range, so unused fields toggle too
  function automatic voice_req_t random_req();
    voice_req_t r;
    r.kind   = 3'($urandom_range(0, 4));
    r.port   = 9'($urandom_range(0, 256) - 1);
    r.chan   = 5'($urandom_range(0, 16) - 1);
    r.key    = 8'($urandom_range(0, 128) - 1);
    if ($urandom_range(0, 3) == 0) r.nid = -1;
    else r.nid = 32'($urandom() >> 1);
    r.rvoice = 4'($urandom_range(0, 15));
    r.rlevel = 16'($urandom());
    r.ridle  = 1'($urandom_range(0, 1));
    r.drain_first = 1'b0;
    return r;
  endfunction

  function automatic voice_req_t note_req(logic [2:0] kind, logic signed [8:0] port,
                                          logic signed [4:0] chan, logic signed [7:0] key,
                                          logic signed [31:0] nid);
    voice_req_t r;
    r = random_req();
    r.kind = kind;
    r.port = port;
    r.chan = chan;
    r.key  = key;
    r.nid  = nid;
    return r;
  endfunction

  function automatic voice_req_t level_req(logic [3:0] voice, logic [15:0] level,
                                           logic idle);
    voice_req_t r;
    r = random_req();
    r.kind   = REQ_REPORT;
    r.rvoice = voice;
    r.rlevel = level;
    r.ridle  = idle;
    return r;
  endfunction

  voice_req_t played_notes[$];
  int         next_nid = 100;

  initial begin : stimulus_and_end
    voice_req_t r;
    int pick;

    // directed: empty table, filling, stealing, matching rules, clears
    queued_requests.push_back(note_req(REQ_NOTE_OFF, -1, -1, -1, -1));  // nothing to release
    queued_requests.push_back(level_req(4'd3, 16'h0001, 1'b1));         // idle on free voice
    queued_requests.push_back(note_req(REQ_NOTE_ON, -1, -1, -1, -1));
    queued_requests.push_back(note_req(REQ_NOTE_ON, 255, 15, 127, 32'sh7fffffff));
    queued_requests.push_back(note_req(REQ_NOTE_ON, 0, 0, 0, 0));
    for (int v = 3; v < NUM_VOICES; v++)
      queued_requests.push_back(note_req(REQ_NOTE_ON, 9'($urandom_range(0, 3)),
                                         5'($urandom_range(0, 1)), 8'(60 + v),
                                         (v % 2 == 0) ? 32'(v * 10) : -1));
    // voice 0 loud, voice 3 slightly up, the rest at zero: steal goes to voice 1
    queued_requests.push_back(level_req(4'd0, 16'hffff, 1'b0));
    queued_requests.push_back(note_req(REQ_NOTE_ON, 255, 3, 127, -1));
    // note id wins over a disagreeing port
    queued_requests.push_back(note_req(REQ_NOTE_OFF, 200, -1, -1, 0));
    // field match with wildcards, only the stolen voice has port 255
    queued_requests.push_back(note_req(REQ_CHOKE, 255, -1, -1, -1));
    queued_requests.push_back(level_req(4'd15, 16'h0000, 1'b1));       // idle on active voice
    queued_requests.push_back(note_req(REQ_ALL_OFF, -1, -1, -1, -1));
    r = random_req();
    r.kind = REQ_FIRST_UNUSED + 3'd2;
    queued_requests.push_back(r);

    // random: mostly note traffic that refers back to recently played notes
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = random_req();
      pick = $urandom_range(0, 99);
      if (pick < 35 || (pick < 60 && played_notes.size() == 0)) begin
        r.kind = REQ_NOTE_ON;
        if ($urandom_range(0, 4) != 0) r.port = 9'($urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0) r.chan = 5'($urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0) r.key  = 8'($urandom_range(36, 84));
        case ($urandom_range(0, 6))
          0, 1:    r.nid = -1;
          2:       ;  // keep the wide random id
          default: r.nid = next_nid++;
        endcase
        played_notes.push_back(r);
        if (played_notes.size() > RECENT_NOTES) void'(played_notes.pop_front());
      end else if (pick < 60) begin
        r = played_notes[$urandom_range(0, played_notes.size() - 1)];
        r.kind = (pick < 52) ? REQ_NOTE_OFF : REQ_CHOKE;
        case ($urandom_range(0, 3))
          0: ;  // exact repeat of the note
          1: begin
            // field match with some wildcards
            r.nid = -1;
            if ($urandom_range(0, 2) == 0) r.port = -1;
            if ($urandom_range(0, 2) == 0) r.chan = -1;
            if ($urandom_range(0, 2) == 0) r.key  = -1;
          end
          2: r.nid = 32'($urandom() >> 1);  // id that should not match
          default: begin
            r.port = 9'($urandom_range(0, 256) - 1);
            r.key  = 8'($urandom_range(0, 128) - 1);
          end
        endcase
        r.rvoice = 4'($urandom_range(0, 15));
        r.rlevel = 16'($urandom());
        r.ridle  = 1'($urandom_range(0, 1));
      end else if (pick < 88) begin
        r.kind = REQ_REPORT;
        case ($urandom_range(0, 5))
          0:       r.rlevel = '0;
          1:       r.rlevel = '1;
          2:       r.rlevel = 16'($urandom_range(0, 7));
          default: ;
        endcase
        r.ridle = ($urandom_range(0, 4) == 0);
      end else if (pick < 91) begin
        r.kind = REQ_ALL_OFF;
      end else if (pick < 94) begin
        r.kind = REQ_FIRST_UNUSED + 3'($urandom_range(0, 2));
      end
      // remaining picks stay fully random noise
      r.drain_first = (i == DRAIN_AT);
      queued_requests.push_back(r);
    end
    total_items = queued_requests.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (!(beats_sent == total_items && results_seen == total_items));
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("polyphonic_voice_allocator_top_test: PASS");
    end else begin
      $display("polyphonic_voice_allocator_top_test: FAIL");
    end
    $finish;
  end

endmodule
